// File: hw/rtl/asc_pkg.sv
// Shared types, constants and helper functions for the analog stick and
// trigger conditioner. No dependencies.
package asc_pkg;

    localparam int AXIS_W      = 16;
    localparam int TRIG_RAW_W  = 8;
    localparam int STICK_OUT_W = 21;
    localparam int TRIG_OUT_W  = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE_MODE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_DEAD_ZONE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_DEAD_ZONE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_FLOOR   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_STICK_GAIN      = 3'd4;

    // Pipeline depths.
    localparam int SQRT_STAGES = 16;
    localparam int SCALE_QW    = 15;
    localparam int RATIO_QW    = 16;
    localparam int STICK_LAT   = 55;
    localparam int TRIG_LAT    = 18;

    typedef struct packed {
        logic        mode;
        logic [15:0] dz;
        logic [15:0] gain;
    } stick_cfg_t;

    function automatic logic [15:0] sat_one(input logic [15:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    // Magnitude of a raw axis scaled by 32768/32767 with rounding. Because the
    // magnitude never exceeds 32768 the quotient is mag plus one exactly when
    // mag is at least 16384.
    function automatic logic [15:0] norm_mag(input logic [15:0] raw);
        logic [15:0] mag;
        mag = raw[15] ? (~raw + 16'd1) : raw;
        return mag + {15'd0, (mag >= 16'd16384)};
    endfunction

endpackage

// File: hw/rtl/asc_delay.sv
// Enable-gated shift register that delays a bus by a fixed number of beats.
// Depends on nothing.
module asc_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] sr_reg [D];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                sr_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            sr_reg[0] <= din;
            for (int i = 1; i < D; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[D-1];
endmodule

// File: hw/rtl/asc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on asc_pkg.
module asc_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] rad,
    output logic [15:0] root
);
    import asc_pkg::*;

    logic [17:0] rem_reg  [SQRT_STAGES];
    logic [15:0] root_reg [SQRT_STAGES];
    logic [31:0] rad_reg  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        logic [17:0] rem_in;
        logic [15:0] root_in;
        logic [31:0] rad_in;
        logic [19:0] acc;
        logic [19:0] trial;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign acc   = {rem_in, rad_in[31:30]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (acc >= trial)
                begin
                    rem_reg[s]  <= 18'(acc - trial);
                    root_reg[s] <= {root_in[14:0], 1'b1};
                end
                else
                begin
                    rem_reg[s]  <= acc[17:0];
                    root_reg[s] <= {root_in[14:0], 1'b0};
                end
                rad_reg[s] <= {rad_in[29:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];
endmodule

// File: hw/rtl/asc_div.sv
// Pipelined restoring divider, one quotient bit per stage. The upper part of
// the numerator must be below the divisor. Depends on nothing.
module asc_div #(
    parameter int NW = 31,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [DW-1:0] den_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] low_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;

        if (s == 0)
        begin : g_first
            assign rem_in = DW'(num[NW-1:QW]);
            assign quo_in = '0;
            assign low_in = num[QW-1:0];
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign low_in = low_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign trial = {rem_in, low_in[QW-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, den_in})
                begin
                    rem_reg[s] <= DW'(trial - {1'b0, den_in});
                    quo_reg[s] <= {quo_in[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= trial[DW-1:0];
                    quo_reg[s] <= {quo_in[QW-2:0], 1'b0};
                end
                low_reg[s] <= {low_in[QW-2:0], 1'b0};
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = quo_reg[QW-1];
endmodule

// File: hw/rtl/asc_trig.sv
// Trigger path: normalize to Q1.15, apply the floor and rescale, then delay
// to line up with the stick path. Depends on asc_pkg, asc_div, asc_delay.
module asc_trig (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [15:0]                     floor_q15,
    input  logic [asc_pkg::TRIG_RAW_W-1:0]  raw,
    output logic [asc_pkg::TRIG_OUT_W-1:0]  trig
);
    import asc_pkg::*;

    logic [14:0] x;
    logic [15:0] q255;
    logic [15:0] t_reg;
    logic [15:0] range;
    logic [15:0] num;
    logic        zero;
    logic        sat;
    logic [15:0] num_reg;
    logic        zero_reg;
    logic        sat_reg;
    logic [14:0] quo;
    logic [1:0]  flags_dly;
    logic [15:0] res_reg;

    // raw*32768/255 is raw*128 plus (raw*128 + 127)/255 after rounding.
    assign x    = {raw, 7'h7f};
    assign q255 = (16'(x) + 16'd1 + 16'(x[14:8])) >> 8;

    assign range = ONE_Q15 - floor_q15;
    assign zero  = (t_reg < floor_q15) || (range == '0);
    assign num   = t_reg - floor_q15;
    assign sat   = num >= range;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= {1'b0, raw, 7'd0} + q255;
            num_reg  <= (zero || sat) ? 16'd0 : num;
            zero_reg <= zero;
            sat_reg  <= sat;
        end
    end

    asc_div #(.NW(31), .DW(16), .QW(SCALE_QW)) u_div (
        .clk (clk),
        .en  (en),
        .num ({num_reg, 15'd0}),
        .den (range),
        .quo (quo)
    );

    asc_delay #(.W(2), .D(SCALE_QW)) u_flag_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({zero_reg, sat_reg}),
        .dout  (flags_dly)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= flags_dly[1] ? 16'd0 : (flags_dly[0] ? ONE_Q15 : {1'b0, quo});
        end
    end

    asc_delay #(.W(TRIG_OUT_W), .D(STICK_LAT - TRIG_LAT)) u_align (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (res_reg),
        .dout  (trig)
    );
endmodule

// File: hw/rtl/asc_stick.sv
// Stick path: normalize both axes, apply a circular or axial dead zone,
// rescale and apply gain. Depends on asc_pkg, asc_isqrt, asc_div, asc_delay.
module asc_stick (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  asc_pkg::stick_cfg_t                     cfg,
    input  logic signed [asc_pkg::AXIS_W-1:0]       x_raw,
    input  logic signed [asc_pkg::AXIS_W-1:0]       y_raw,
    output logic signed [asc_pkg::STICK_OUT_W-1:0]  x_out,
    output logic signed [asc_pkg::STICK_OUT_W-1:0]  y_out
);
    import asc_pkg::*;

    // Normalize and square.
    logic [15:0] qx_reg, qy_reg;
    logic        sx_reg, sy_reg;
    logic [31:0] sqx_reg, sqy_reg;
    logic [31:0] sum_reg;
    logic [15:0] mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg  <= norm_mag(x_raw);
            qy_reg  <= norm_mag(y_raw);
            sx_reg  <= x_raw[15];
            sy_reg  <= y_raw[15];
            sqx_reg <= qx_reg * qx_reg;
            sqy_reg <= qy_reg * qy_reg;
            sum_reg <= sqx_reg + sqy_reg;
        end
    end

    asc_isqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (sum_reg),
        .root (mag)
    );

    logic [33:0] side_a;
    logic        sx_a, sy_a;
    logic [15:0] qx_a, qy_a;

    asc_delay #(.W(34), .D(SQRT_STAGES + 2)) u_dly_a (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({sx_reg, sy_reg, qx_reg, qy_reg}),
        .dout  (side_a)
    );
    assign {sx_a, sy_a, qx_a, qy_a} = side_a;

    // Dead zone test and numerators of the rescale.
    logic [15:0] range;
    logic        zero_c, zero_x, zero_y;
    logic [15:0] num0, num1;
    logic        zero0, sat0, sat1;

    assign range  = ONE_Q15 - cfg.dz;
    assign zero_c = (mag <= cfg.dz) || (range == '0);
    assign zero_x = (qx_a < cfg.dz) || (range == '0);
    assign zero_y = (qy_a < cfg.dz) || (range == '0);
    assign num0   = cfg.mode ? (qx_a - cfg.dz) : (mag - cfg.dz);
    assign num1   = qy_a - cfg.dz;
    assign zero0  = cfg.mode ? zero_x : zero_c;
    assign sat0   = num0 >= range;
    assign sat1   = num1 >= range;

    logic [15:0] dnum0_reg, dnum1_reg;
    logic [53:0] side_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dnum0_reg  <= (zero0 || sat0) ? 16'd0 : num0;
            dnum1_reg  <= (zero_y || sat1) ? 16'd0 : num1;
            side_b_reg <= {zero0, sat0, zero_y, sat1, sx_a, sy_a, qx_a, qy_a, mag};
        end
    end

    logic [SCALE_QW-1:0] sq0, sq1;

    asc_div #(.NW(31), .DW(16), .QW(SCALE_QW)) u_scale0 (
        .clk (clk),
        .en  (en),
        .num ({dnum0_reg, 15'd0}),
        .den (range),
        .quo (sq0)
    );

    asc_div #(.NW(31), .DW(16), .QW(SCALE_QW)) u_scale1 (
        .clk (clk),
        .en  (en),
        .num ({dnum1_reg, 15'd0}),
        .den (range),
        .quo (sq1)
    );

    logic [53:0] side_b;
    logic        z0_b, s0_b, z1_b, s1_b, sx_b, sy_b;
    logic [15:0] qx_b, qy_b, m_b;

    asc_delay #(.W(54), .D(SCALE_QW)) u_dly_b (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (side_b_reg),
        .dout  (side_b)
    );
    assign {z0_b, s0_b, z1_b, s1_b, sx_b, sy_b, qx_b, qy_b, m_b} = side_b;

    // Resolve the scale factors, then form the products for the radial ratio.
    logic [15:0] n0_reg, n1_reg;
    logic [15:0] qx_c, qy_c, m_c;
    logic        sx_c, sy_c;
    logic [30:0] px_reg, py_reg;
    logic [15:0] den_reg;
    logic [33:0] side_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg <= z0_b ? 16'd0 : (s0_b ? ONE_Q15 : {1'b0, sq0});
            n1_reg <= z1_b ? 16'd0 : (s1_b ? ONE_Q15 : {1'b0, sq1});
            qx_c   <= qx_b;
            qy_c   <= qy_b;
            m_c    <= m_b;
            sx_c   <= sx_b;
            sy_c   <= sy_b;

            px_reg     <= 31'({15'd0, qx_c} * {15'd0, n0_reg});
            py_reg     <= 31'({15'd0, qy_c} * {15'd0, n0_reg});
            // A zero magnitude only occurs inside the dead zone, where the
            // product is zero anyway; a divisor of one keeps the quotient zero.
            den_reg    <= (m_c == '0) ? 16'd1 : m_c;
            side_d_reg <= {sx_c, sy_c, n0_reg, n1_reg};
        end
    end

    logic [RATIO_QW-1:0] rx, ry;

    asc_div #(.NW(31), .DW(16), .QW(RATIO_QW)) u_ratio_x (
        .clk (clk),
        .en  (en),
        .num (px_reg),
        .den (den_reg),
        .quo (rx)
    );

    asc_div #(.NW(31), .DW(16), .QW(RATIO_QW)) u_ratio_y (
        .clk (clk),
        .en  (en),
        .num (py_reg),
        .den (den_reg),
        .quo (ry)
    );

    logic [33:0] side_d;
    logic        sx_d, sy_d;
    logic [15:0] ax_d, ay_d;

    asc_delay #(.W(34), .D(RATIO_QW)) u_dly_d (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (side_d_reg),
        .dout  (side_d)
    );
    assign {sx_d, sy_d, ax_d, ay_d} = side_d;

    // Gain and sign. The product magnitude stays below 2^20, so it always
    // fits the signed output.
    logic [31:0] gx_reg, gy_reg;
    logic        sx_e, sy_e;
    logic signed [STICK_OUT_W-1:0] ox_reg, oy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg <= (cfg.mode ? ax_d : rx) * cfg.gain;
            gy_reg <= (cfg.mode ? ay_d : ry) * cfg.gain;
            sx_e   <= sx_d;
            sy_e   <= sy_d;
            ox_reg <= sx_e ? -$signed({1'b0, gx_reg[31:12]}) : $signed({1'b0, gx_reg[31:12]});
            oy_reg <= sy_e ? -$signed({1'b0, gy_reg[31:12]}) : $signed({1'b0, gy_reg[31:12]});
        end
    end

    assign x_out = ox_reg;
    assign y_out = oy_reg;
endmodule

// File: hw/rtl/analog_stick_trigger_conditioner.sv
// Top level of the analog stick and trigger conditioner: configuration
// registers, stream handshake and the stick and trigger pipelines.
// Depends on asc_pkg, asc_stick, asc_trig, asc_delay.

// The block takes one controller sample per clock unless the output stalls and
// returns one conditioned sample for each; with the output side ready it
// sustains one beat per cycle. The depth comes from the square root of the
// stick magnitude and the two rescale divisions, each resolved one bit per
// pipeline stage. A stall on the output holds the whole pipeline in place.
// Configuration registers may be written only while no sample is in flight.
module analog_stick_trigger_conditioner (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // lx_raw[15:0], ly_raw[31:16], rx_raw[47:32], ry_raw[63:48],
    // lt_raw[71:64], rt_raw[79:72]
    input  logic [79:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // left_stick_x[20:0], left_stick_y[41:21], right_stick_x[62:42],
    // right_stick_y[83:63], left_trigger[99:84], right_trigger[115:100], zero
    output logic [119:0]                     m_tdata,
    input  logic                             cfg_we,
    input  logic [asc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [asc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import asc_pkg::*;

    logic        dead_zone_mode_reg;
    logic [15:0] left_dead_zone_reg;
    logic [15:0] right_dead_zone_reg;
    logic [15:0] trigger_floor_reg;
    logic [15:0] stick_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_mode_reg  <= 1'b0;
            left_dead_zone_reg  <= '0;
            right_dead_zone_reg <= '0;
            trigger_floor_reg   <= '0;
            stick_gain_reg      <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DEAD_ZONE_MODE:  dead_zone_mode_reg  <= cfg_wdata[0];
                REG_LEFT_DEAD_ZONE:  left_dead_zone_reg  <= cfg_wdata;
                REG_RIGHT_DEAD_ZONE: right_dead_zone_reg <= cfg_wdata;
                REG_TRIGGER_FLOOR:   trigger_floor_reg   <= cfg_wdata;
                REG_STICK_GAIN:      stick_gain_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    stick_cfg_t lcfg, rcfg;
    logic [15:0] floor_q15;

    assign lcfg      = '{mode: dead_zone_mode_reg, dz: sat_one(left_dead_zone_reg),
                         gain: stick_gain_reg};
    assign rcfg      = '{mode: dead_zone_mode_reg, dz: sat_one(right_dead_zone_reg),
                         gain: stick_gain_reg};
    assign floor_q15 = sat_one(trigger_floor_reg);

    // The pipeline moves as a whole whenever its last stage is empty or taken.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    asc_delay #(.W(1), .D(STICK_LAT)) u_valid (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (s_tvalid),
        .dout  (m_tvalid)
    );

    logic signed [STICK_OUT_W-1:0] left_stick_x, left_stick_y;
    logic signed [STICK_OUT_W-1:0] right_stick_x, right_stick_y;
    logic [TRIG_OUT_W-1:0]         left_trigger, right_trigger;

    asc_stick u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (lcfg),
        .x_raw (s_tdata[15:0]),
        .y_raw (s_tdata[31:16]),
        .x_out (left_stick_x),
        .y_out (left_stick_y)
    );

    asc_stick u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (rcfg),
        .x_raw (s_tdata[47:32]),
        .y_raw (s_tdata[63:48]),
        .x_out (right_stick_x),
        .y_out (right_stick_y)
    );

    asc_trig u_ltrig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .floor_q15 (floor_q15),
        .raw       (s_tdata[71:64]),
        .trig      (left_trigger)
    );

    asc_trig u_rtrig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .floor_q15 (floor_q15),
        .raw       (s_tdata[79:72]),
        .trig      (right_trigger)
    );

    assign m_tdata = {4'd0, right_trigger, left_trigger, right_stick_y, right_stick_x,
                      left_stick_y, left_stick_x};

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (left_trigger <= ONE_Q15) && (right_trigger <= ONE_Q15))
        else $error("trigger output above full scale");

    a_trig_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (floor_q15 == ONE_Q15) |-> (left_trigger == '0) && (right_trigger == '0))
        else $error("trigger not zero with floor at full scale");

    a_stick_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (left_stick_x <= 21'sd524280) && (left_stick_x >= -21'sd524280)
                  && (right_stick_y <= 21'sd524280) && (right_stick_y >= -21'sd524280))
        else $error("stick output beyond gain range");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for analog_stick_trigger_conditioner.
// Drives random and directed controller samples over the stream ports, predicts each
// result in-bench and compares it field by field. Depends on asc_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import asc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    typedef struct packed {
        logic [15:0] rt;
        logic [15:0] lt;
        logic [20:0] ry;
        logic [20:0] rx;
        logic [20:0] ly;
        logic [20:0] lx;
    } cond_t;

    typedef struct {
        logic [79:0] data;
        logic        has_exp;
        cond_t       exp;
    } row_t;

    // Configuration shadow.
    logic        mode_q;
    logic [15:0] ldz_q, rdz_q, floor_q, gain_q;

    cond_t  expected_q[$];
    int     errors;
    int     samples_sent;
    int     results_seen;
    int     idle_pct;

    analog_stick_trigger_conditioner uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("[analog_stick_trigger_conditioner] ERROR");
        $finish;
    end

    function automatic longint norm_axis(logic [15:0] r);
        longint mag;
        longint q;
        mag = r[15] ? (65536 - longint'(r)) : longint'(r);
        q = (mag * 32768 + 16383) / 32767;
        return r[15] ? -q : q;
    endfunction

    function automatic longint labs(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_one(longint v);
        return v > 32768 ? 32768 : v;
    endfunction

    function automatic longint axial_axis(longint a, longint dz);
        longint m;
        longint v;
        m = labs(a);
        if (m < dz || dz == 32768)
            return 0;
        v = clamp_one(((m - dz) * 32768) / (32768 - dz));
        return a < 0 ? -v : v;
    endfunction

    function automatic logic [20:0] apply_gain(longint v);
        longint p;
        p = (labs(v) * longint'(gain_q)) >>> 12;
        if (v < 0)
            p = -p;
        if (p > 1048575)
            p = 1048575;
        if (p < -1048576)
            p = -1048576;
        return p[20:0];
    endfunction

    function automatic void condition_stick(input logic [15:0] xr, input logic [15:0] yr,
                                            input logic [15:0] dz_reg,
                                            output logic [20:0] ox, output logic [20:0] oy);
        longint x, y, dz, m, n, vx, vy;
        x = norm_axis(xr);
        y = norm_axis(yr);
        dz = clamp_one(longint'(dz_reg));
        if (mode_q)
        begin
            vx = axial_axis(x, dz);
            vy = axial_axis(y, dz);
        end
        else
        begin
            m = int_sqrt(x * x + y * y);
            if (m <= dz || dz == 32768)
            begin
                vx = 0;
                vy = 0;
            end
            else
            begin
                n = clamp_one(((m - dz) * 32768) / (32768 - dz));
                vx = (labs(x) * n) / m;
                vy = (labs(y) * n) / m;
                if (x < 0)
                    vx = -vx;
                if (y < 0)
                    vy = -vy;
            end
        end
        ox = apply_gain(vx);
        oy = apply_gain(vy);
    endfunction

    function automatic logic [15:0] rescale_trigger(logic [7:0] raw);
        longint t;
        longint fl;
        longint v;
        t = (longint'(raw) * 32768 + 127) / 255;
        fl = clamp_one(longint'(floor_q));
        if (t < fl || fl == 32768)
            return 16'd0;
        v = ((t - fl) * 32768) / (32768 - fl);
        return v[15:0];
    endfunction

    function automatic cond_t predict_sample(logic [79:0] d);
        cond_t c;
        condition_stick(d[15:0], d[31:16], ldz_q, c.lx, c.ly);
        condition_stick(d[47:32], d[63:48], rdz_q, c.rx, c.ry);
        c.lt = rescale_trigger(d[71:64]);
        c.rt = rescale_trigger(d[79:72]);
        return c;
    endfunction

    function automatic logic [79:0] pack_sample(logic [15:0] lx, logic [15:0] ly,
                                                logic [15:0] rx, logic [15:0] ry,
                                                logic [7:0] lt, logic [7:0] rt);
        return {rt, lt, ry, rx, ly, lx};
    endfunction

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_DEAD_ZONE_MODE:  mode_q  = val[0];
            REG_LEFT_DEAD_ZONE:  ldz_q   = val;
            REG_RIGHT_DEAD_ZONE: rdz_q   = val;
            REG_TRIGGER_FLOOR:   floor_q = val;
            REG_STICK_GAIN:      gain_q  = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (STICK_LAT + 10) @(posedge clk);
    endtask

    // Hands one beat to the block; the valid stays high into the next beat.
    task automatic send_sample(input logic [79:0] d);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(predict_sample(d));
        samples_sent++;
    endtask

    task automatic end_burst;
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5, 0))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(2000, 0));
            3: return 16'(-$urandom_range(2000, 0));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_zone();
        case ($urandom_range(5, 0))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(65535, 32769));
            default: return 16'($urandom_range(16000, 0));
        endcase
    endfunction

    // Sink: random stalls and field-by-field compare.
    always @(posedge clk)
    begin
        cond_t got;
        cond_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[115:0];
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%t unexpected result %h", $realtime, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.lx !== want.lx)
                begin
                    $display("%t left_stick_x exp %h got %h", $realtime, want.lx, got.lx);
                    errors++;
                end
                if (got.ly !== want.ly)
                begin
                    $display("%t left_stick_y exp %h got %h", $realtime, want.ly, got.ly);
                    errors++;
                end
                if (got.rx !== want.rx)
                begin
                    $display("%t right_stick_x exp %h got %h", $realtime, want.rx, got.rx);
                    errors++;
                end
                if (got.ry !== want.ry)
                begin
                    $display("%t right_stick_y exp %h got %h", $realtime, want.ry, got.ry);
                    errors++;
                end
                if (got.lt !== want.lt)
                begin
                    $display("%t left_trigger exp %h got %h", $realtime, want.lt, got.lt);
                    errors++;
                end
                if (got.rt !== want.rt)
                begin
                    $display("%t right_trigger exp %h got %h", $realtime, want.rt, got.rt);
                    errors++;
                end
                if (m_tdata[119:116] !== 4'd0)
                begin
                    $display("%t pad bits exp 0 got %h", $realtime, m_tdata[119:116]);
                    errors++;
                end
            end
        end
        m_tready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99, 0) >= idle_pct);
    end

    initial
    begin
        row_t  rows[$];
        row_t  r;
        cond_t c;
        int    n;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        errors    = 0;
        samples_sent = 0;
        results_seen = 0;
        idle_pct  = 0;
        mode_q = 1'b0;
        ldz_q = 16'd0;
        rdz_q = 16'd0;
        floor_q = 16'd0;
        gain_q = GAIN_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings; exact results only where obvious.
        c = '0;
        r.data = '0; r.has_exp = 1'b1; r.exp = c; rows.push_back(r);
        // Full-scale positive axis normalizes to exactly 1.0.
        c = '0; c.lx = 21'd32768; c.lt = 16'd32768; c.rt = 16'd32768;
        r.data = pack_sample(16'h7FFF, 16'd0, 16'd0, 16'd0, 8'hFF, 8'hFF);
        r.exp = c; rows.push_back(r);
        r.has_exp = 1'b0;
        r.data = pack_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 8'h01, 8'h80);
        rows.push_back(r);
        r.data = pack_sample(16'hFFFF, 16'h0001, 16'h5A82, 16'hA57E, 8'h7F, 8'h00);
        rows.push_back(r);
        r.data = pack_sample(16'h4000, 16'hC000, 16'h3FFF, 16'hBFFF, 8'hAA, 8'h55);
        rows.push_back(r);
        foreach (rows[i])
        begin
            send_sample(rows[i].data);
            if (rows[i].has_exp)
                expected_q[expected_q.size()-1] = rows[i].exp;
        end
        end_burst();
        drain();

        // Configuration phases: extremes first, then random settings.
        for (int ph = 0; ph < 24; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_DEAD_ZONE_MODE, 16'd1);
                    write_reg(REG_LEFT_DEAD_ZONE, 16'd32768);
                    write_reg(REG_RIGHT_DEAD_ZONE, 16'hFFFF);
                    write_reg(REG_TRIGGER_FLOOR, 16'd32768);
                    write_reg(REG_STICK_GAIN, 16'hFFFF);
                end
                1:
                begin
                    write_reg(REG_DEAD_ZONE_MODE, 16'd0);
                    write_reg(REG_TRIGGER_FLOOR, 16'hFFFF);
                    write_reg(REG_STICK_GAIN, 16'd0);
                end
                2:
                begin
                    write_reg(REG_LEFT_DEAD_ZONE, 16'd0);
                    write_reg(REG_RIGHT_DEAD_ZONE, 16'd32767);
                    write_reg(REG_TRIGGER_FLOOR, 16'd32767);
                    write_reg(REG_STICK_GAIN, 16'hFFFF);
                end
                default:
                begin
                    write_reg(REG_DEAD_ZONE_MODE, 16'($urandom_range(1, 0)));
                    write_reg(REG_LEFT_DEAD_ZONE, rand_zone());
                    write_reg(REG_RIGHT_DEAD_ZONE, rand_zone());
                    write_reg(REG_TRIGGER_FLOOR, rand_zone());
                    write_reg(REG_STICK_GAIN, ($urandom_range(3, 0) == 0) ?
                              16'hFFFF : 16'($urandom));
                end
            endcase
            cfg_we <= 1'b0;
            // Phase 5 runs with no idling on either side.
            idle_pct = (ph == 5) ? 0 : 8;
            n = (ph < 3) ? 12 : 72;
            for (int k = 0; k < n; k++)
                send_sample(pack_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                                        8'($urandom), 8'($urandom)));
            end_burst();
            drain();
        end

        $display("Sent %0d samples over 24 settings, checked %0d results.",
                 samples_sent, results_seen);
        if (errors == 0)
            $display("[analog_stick_trigger_conditioner] OK");
        else
            $display("[analog_stick_trigger_conditioner] ERROR");
        $finish;
    end
endmodule
